// File: rtl/core/brd_pkg.sv
`default_nettype none

package brd_pkg;

   // request kinds
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERLAP  = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd3;

   // largest region, one full bus span
   localparam logic [16:0] SIZE_CAP = 17'h10000;

   // entries in the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_READ,
      OP_WRITE,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [16:0] region_size;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  region_index;
      logic [15:0] offset;
      logic        is_write;
      logic [7:0]  data_out;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      op_type      op;
      logic [15:0] address;
      logic [16:0] region_end;
      logic [7:0]  write_data;
   } cmd_type;

   // queue handshake
   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// File: rtl/core/bus_region_decoder.sv
`default_nettype none

// Address decoder for a 16-bit bus with a table of up to MAX_REGIONS regions,
// each a half-open range [base, base + size). Requests go in through a queue
// style port (push/full) and results come out the same way (pop/empty), one
// result per request, in order. An add request checks the new region against
// every region held and stores it at the next index when it overlaps nothing
// and the table has room; a read or write request returns the index of the
// highest-numbered region that holds the address and the offset from its base.
// Timing: the front side classifies each request in the cycle it is pushed and
// parks it in a two-entry command queue. The back side walks the region table
// one entry per cycle through a single registered read port, and goes straight
// to the result when the table is empty or the kind is unused. The finished
// result sits in an output register, so the back side keeps working while it
// waits to be popped.

module bus_region_decoder #(
   parameter int MAX_REGIONS = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   // request side
   input  wire                    req_push,
   output logic                   req_full,
   input  wire  brd_pkg::req_type  req_data,
   // result side
   input  wire                    rsp_pop,
   output logic                   rsp_empty,
   output brd_pkg::rsp_type       rsp_data
);

   brd_pkg::cmd_type   front_cmd;   // classified request from the front
   brd_pkg::cmd_type   queue_cmd;   // oldest queued request for the back
   brd_pkg::qctl_type  queue_ctl;
   brd_pkg::qstat_type queue_stat;
   logic               back_pop;

   // front: size saturation, end computation, kind decode
   brd_front u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   assign queue_ctl.push = req_push;
   assign queue_ctl.pop  = back_pop;
   assign req_full       = queue_stat.full;

   // short queue decoupling the two sides
   brd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctl    (queue_ctl),
      .wr_cmd (front_cmd),
      .stat   (queue_stat),
      .rd_cmd (queue_cmd)
   );

   // back: table scan, add/lookup, result register
   brd_back #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_cmd     (queue_cmd),
      .q_empty   (queue_stat.empty),
      .q_pop     (back_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/core/brd_front.sv
`default_nettype none

module brd_front (
   input  wire  brd_pkg::req_type req_data,
   output brd_pkg::cmd_type       cmd
);

   logic [16:0] size_sat;

   // oversize regions saturate to the full bus span
   assign size_sat = (req_data.region_size > brd_pkg::SIZE_CAP) ?
                     brd_pkg::SIZE_CAP : req_data.region_size;

   always_comb begin
      cmd.address    = req_data.address;
      cmd.write_data = req_data.write_data;
      // 17-bit end, cannot wrap
      cmd.region_end = {1'b0, req_data.address} + size_sat;
      unique case (req_data.kind)
         brd_pkg::KIND_ADD:   cmd.op = brd_pkg::OP_ADD;
         brd_pkg::KIND_READ:  cmd.op = brd_pkg::OP_READ;
         brd_pkg::KIND_WRITE: cmd.op = brd_pkg::OP_WRITE;
         default:             cmd.op = brd_pkg::OP_NOP;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/brd_queue.sv
`default_nettype none

module brd_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  brd_pkg::qctl_type ctl,
   input  wire  brd_pkg::cmd_type  wr_cmd,
   output brd_pkg::qstat_type     stat,
   output brd_pkg::cmd_type       rd_cmd
);

   localparam int PW = (brd_pkg::QUEUE_DEPTH > 1) ? $clog2(brd_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(brd_pkg::QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(brd_pkg::QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_PTR    = PW'(brd_pkg::QUEUE_DEPTH - 1);

   brd_pkg::cmd_type entry_ff [brd_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign stat.full  = (count_ff == DEPTH_COUNT);
   assign stat.empty = (count_ff == '0);
   assign do_push    = ctl.push && !stat.full;
   assign do_pop     = ctl.pop && !stat.empty;
   assign rd_cmd     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("queue count above depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      stat.full && !do_pop |=> stat.full)
      else $error("queue lost an entry while full");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == DEPTH_COUNT) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step");

endmodule

`default_nettype wire

// File: rtl/core/brd_back.sv
`default_nettype none

module brd_back #(
   parameter int MAX_REGIONS = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  brd_pkg::cmd_type  q_cmd,
   input  wire                    q_empty,
   output logic                   q_pop,
   input  wire                    rsp_pop,
   output logic                   rsp_empty,
   output brd_pkg::rsp_type       rsp_data
);

   localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_REGIONS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   brd_pkg::cmd_type cur_ff;
   logic [CW-1:0]    count_ff;
   logic [IW-1:0]    idx_ff;
   logic [IW-1:0]    chk_idx_ff;
   logic             chk_ff;
   logic [32:0]      rd_ff;
   logic             overlap_ff;
   logic             found_ff;
   logic [IW-1:0]    hit_ff;
   logic [15:0]      hit_base_ff;
   logic             out_valid_ff;
   brd_pkg::rsp_type out_ff;

   // base in [32:17], end in [16:0]
   logic [32:0]      region_mem [MAX_REGIONS];

   logic [15:0]      rd_base;
   logic [16:0]      rd_end;
   logic             ovl_hit;
   logic             addr_hit;
   logic             overlap_in;
   logic             found_in;
   logic [IW-1:0]    hit_in;
   logic [15:0]      hit_base_in;
   logic             fire;
   logic             add_ok;
   logic             mem_we;
   brd_pkg::rsp_type rsp_in;

   assign rd_base  = rd_ff[32:17];
   assign rd_end   = rd_ff[16:0];
   // half-open intervals: touching is no overlap
   assign ovl_hit  = ({1'b0, cur_ff.address} < rd_end) &&
                     ({1'b0, rd_base} < cur_ff.region_end);
   assign addr_hit = (rd_base <= cur_ff.address) && ({1'b0, cur_ff.address} < rd_end);

   // a newly taken request clears the scan results;
   // later entries overwrite the hit: last match wins
   assign overlap_in  = !q_pop && (overlap_ff || (chk_ff && ovl_hit));
   assign found_in    = !q_pop && (found_ff || (chk_ff && addr_hit));
   assign hit_in      = q_pop ? '0 : (chk_ff && addr_hit) ? chk_idx_ff : hit_ff;
   assign hit_base_in = q_pop ? '0 : (chk_ff && addr_hit) ? rd_base : hit_base_ff;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign fire      = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_pop);
   assign mem_we    = fire && add_ok;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      rsp_in = '0;
      add_ok = 1'b0;
      unique case (cur_ff.op)
         brd_pkg::OP_ADD: begin
            if (overlap_ff) begin
               rsp_in.status = brd_pkg::STATUS_OVERLAP;
            end else if (count_ff == FULL_COUNT) begin
               rsp_in.status = brd_pkg::STATUS_FULL;
            end else begin
               rsp_in.status       = brd_pkg::STATUS_OK;
               rsp_in.region_index = 3'(count_ff);
               add_ok              = 1'b1;
            end
         end
         brd_pkg::OP_READ, brd_pkg::OP_WRITE: begin
            if (!found_ff) begin
               rsp_in.status = brd_pkg::STATUS_UNMAPPED;
            end else begin
               rsp_in.status       = brd_pkg::STATUS_OK;
               rsp_in.region_index = 3'(hit_ff);
               rsp_in.offset       = cur_ff.address - hit_base_ff;
               if (cur_ff.op == brd_pkg::OP_WRITE) begin
                  rsp_in.is_write = 1'b1;
                  rsp_in.data_out = cur_ff.write_data;
               end
            end
         end
         default: begin
            rsp_in.status = brd_pkg::STATUS_OK;
         end
      endcase
   end

   // region table, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         region_mem[count_ff[IW-1:0]] <= {cur_ff.address, cur_ff.region_end};
      end
      rd_ff <= region_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         chk_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         overlap_ff  <= overlap_in;
         found_ff    <= found_in;
         hit_ff      <= hit_in;
         hit_base_ff <= hit_base_in;
         // table data for the entry addressed now arrives next cycle
         chk_ff      <= (state_ff == ST_SCAN);
         if (fire) begin
            out_valid_ff <= 1'b1;
            out_ff       <= rsp_in;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (mem_we) begin
            count_ff <= count_ff + 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  cur_ff <= q_cmd;
                  idx_ff <= '0;
                  if (count_ff == '0 || q_cmd.op == brd_pkg::OP_NOP) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               chk_idx_ff <= idx_ff;
               if (idx_ff == IW'(count_ff - 1'b1)) begin
                  state_ff <= ST_LAST;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_LAST: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (fire) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("region count above table size");

   a_read_written: assert property (@(posedge clock) disable iff (reset)
      chk_ff |-> {1'b0, chk_idx_ff} < (IW + 1)'(count_ff))
      else $error("table entry checked beyond region count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff) |->
         count_ff == $past(count_ff) + 1'b1)
      else $error("region count moved by other than one");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != brd_pkg::STATUS_OK |->
         out_ff.region_index == '0 && out_ff.offset == '0 && !out_ff.is_write)
      else $error("rejected result carries payload");

endmodule

`default_nettype wire

// File: dv/bus_region_decoder_test.sv
`timescale 1ns / 100ps

module bus_region_decoder_test;

   localparam int TABLE_DEPTH  = 8;
   localparam int RANDOM_COUNT = 1600;
   // last stretch of the random part runs with no idling on either side
   localparam int QUIET_FROM   = RANDOM_COUNT - 200;
   // receiver hold-off long enough to back the request queue up into req_full
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 80;
   // sender waits here until every outstanding request has answered
   localparam int DRAIN_AT     = 800;
   // the limit sits several times above the worst case, a full table on every
   // request plus the longest idle stretches on each side
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int SETTLE       = 16;

   // Region table model plus the in-order list of expected results.
   class region_scoreboard;
      logic [15:0]      base_addr[TABLE_DEPTH];
      logic [16:0]      end_addr[TABLE_DEPTH];
      int               held;
      brd_pkg::rsp_type expected_q[$];
      int               errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Work out the result of one accepted request and update the table.
      function void note_request(brd_pkg::req_type r);
         brd_pkg::rsp_type want;
         logic [16:0]      span;
         logic [16:0]      top;
         bit               clash;
         bit               found;
         int               hit;
         want  = '0;
         clash = 0;
         found = 0;
         hit   = 0;
         case (r.kind)
            brd_pkg::KIND_ADD: begin
               span = (r.region_size > brd_pkg::SIZE_CAP) ? brd_pkg::SIZE_CAP
                                                          : r.region_size;
               top  = {1'b0, r.address} + span;
               for (int i = 0; i < held; i++)
                  if ({1'b0, r.address} < end_addr[i] && {1'b0, base_addr[i]} < top)
                     clash = 1;
               if (clash) begin
                  want.status = brd_pkg::STATUS_OVERLAP;
               end else if (held >= TABLE_DEPTH) begin
                  want.status = brd_pkg::STATUS_FULL;
               end else begin
                  base_addr[held]   = r.address;
                  end_addr[held]    = top;
                  want.status       = brd_pkg::STATUS_OK;
                  want.region_index = 3'(held);
                  held++;
               end
            end
            brd_pkg::KIND_READ, brd_pkg::KIND_WRITE: begin
               // highest matching index wins
               for (int i = 0; i < held; i++)
                  if (base_addr[i] <= r.address && {1'b0, r.address} < end_addr[i]) begin
                     found = 1;
                     hit   = i;
                  end
               if (!found) begin
                  want.status = brd_pkg::STATUS_UNMAPPED;
               end else begin
                  want.status       = brd_pkg::STATUS_OK;
                  want.region_index = 3'(hit);
                  want.offset       = r.address - base_addr[hit];
                  if (r.kind == brd_pkg::KIND_WRITE) begin
                     want.is_write = 1'b1;
                     want.data_out = r.write_data;
                  end
               end
            end
            default: want.status = brd_pkg::STATUS_OK;
         endcase
         expected_q.push_back(want);
      endfunction

      function void field_check(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(brd_pkg::rsp_type got);
         brd_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         field_check("status", want.status, got.status);
         field_check("region_index", want.region_index, got.region_index);
         field_check("offset", want.offset, got.offset);
         field_check("is_write", want.is_write, got.is_write);
         field_check("data_out", want.data_out, got.data_out);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   brd_pkg::req_type req_data;
   logic             rsp_pop;
   logic             rsp_empty;
   brd_pkg::rsp_type rsp_data;

   region_scoreboard sb;
   bit quiet;        // no idling on either side from here on
   bit hold_wanted;  // sender asks the receiver for one long hold-off
   int cycles;

   bus_region_decoder #(.MAX_REGIONS(TABLE_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic brd_pkg::req_type make_request(logic [1:0] kind, logic [15:0] addr,
                                                     logic [16:0] span, logic [7:0] data);
      brd_pkg::req_type r;
      r.kind        = kind;
      r.address     = addr;
      r.region_size = span;
      r.write_data  = data;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   // req_push stays high so back-to-back requests need no extra assignment.
   task automatic send_request(brd_pkg::req_type r);
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_push <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Directed opening: edges of every field, every kind, touching regions,
   // empty and oversized regions, then a full table with and without overlap.
   task automatic run_directed();
      send_request(make_request(brd_pkg::KIND_READ,  16'h0000, 17'h00000, 8'h00)); // empty table
      send_request(make_request(brd_pkg::KIND_NONE,  16'hFFFF, 17'h1FFFF, 8'hFF)); // unused kind
      send_request(make_request(brd_pkg::KIND_ADD,   16'h1000, 17'h00100, 8'h00));
      send_request(make_request(brd_pkg::KIND_ADD,   16'h1100, 17'h00100, 8'h00)); // touches end
      send_request(make_request(brd_pkg::KIND_ADD,   16'h0F00, 17'h00100, 8'h00)); // touches start
      send_request(make_request(brd_pkg::KIND_ADD,   16'h10FF, 17'h00002, 8'h00)); // straddles
      send_request(make_request(brd_pkg::KIND_ADD,   16'h0000, 17'h00000, 8'h00)); // empty region
      send_request(make_request(brd_pkg::KIND_READ,  16'h0000, 17'h00000, 8'h00)); // matches none
      send_request(make_request(brd_pkg::KIND_ADD,   16'hF000, 17'h1FFFF, 8'h00)); // saturated
      send_request(make_request(brd_pkg::KIND_READ,  16'hFFFF, 17'h00000, 8'h00)); // top of bus
      send_request(make_request(brd_pkg::KIND_WRITE, 16'hF000, 17'h00000, 8'hA5));
      send_request(make_request(brd_pkg::KIND_READ,  16'h1000, 17'h00000, 8'h00));
      send_request(make_request(brd_pkg::KIND_WRITE, 16'h11FF, 17'h00000, 8'h5A));
      send_request(make_request(brd_pkg::KIND_WRITE, 16'h0FFF, 17'h00000, 8'hFF));
      send_request(make_request(brd_pkg::KIND_READ,  16'h1200, 17'h00000, 8'h00)); // past end
      send_request(make_request(brd_pkg::KIND_ADD,   16'h8000, 17'h10000, 8'h00)); // overlaps
      send_request(make_request(brd_pkg::KIND_ADD,   16'h4000, 17'h01000, 8'h00));
      send_request(make_request(brd_pkg::KIND_ADD,   16'h2000, 17'h00001, 8'h00));
      send_request(make_request(brd_pkg::KIND_ADD,   16'h6000, 17'h00800, 8'h00)); // last slot
      send_request(make_request(brd_pkg::KIND_ADD,   16'h3000, 17'h00010, 8'h00)); // table full
      send_request(make_request(brd_pkg::KIND_ADD,   16'h4800, 17'h00004, 8'h00)); // overlap wins
      send_request(make_request(brd_pkg::KIND_ADD,   16'h0000, 17'h00000, 8'h00)); // empty, full
      send_request(make_request(brd_pkg::KIND_WRITE, 16'h7000, 17'h00000, 8'hC3)); // unmapped
      send_request(make_request(brd_pkg::KIND_READ,  16'h2000, 17'h00000, 8'h00));
      send_request(make_request(brd_pkg::KIND_NONE,  16'h0000, 17'h00000, 8'h00));
   endtask

   // Random request; accesses lean toward the edges of regions already held.
   function automatic brd_pkg::req_type random_request();
      brd_pkg::req_type r;
      int               roll;
      int               pick;
      logic [16:0]      edge_addr;
      roll          = $urandom_range(0, 99);
      r.address     = 16'($urandom_range(0, 16'hFFFF));
      r.region_size = 17'($urandom_range(0, 17'h1FFFF));
      r.write_data  = 8'($urandom_range(0, 8'hFF));
      if (roll < 12) begin
         r.kind = brd_pkg::KIND_ADD;
         case ($urandom_range(0, 3))
            0: r.region_size = 17'($urandom_range(1, 16'h0400));
            1: r.region_size = 17'h00000;
            2: r.region_size = brd_pkg::SIZE_CAP;
            default: ;
         endcase
      end else if (roll < 17) begin
         r.kind = brd_pkg::KIND_NONE;
      end else begin
         r.kind = (roll < 58) ? brd_pkg::KIND_READ : brd_pkg::KIND_WRITE;
         if (sb.held > 0 && $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, sb.held - 1);
            case ($urandom_range(0, 4))
               0: edge_addr = {1'b0, sb.base_addr[pick]};
               1: edge_addr = {1'b0, sb.base_addr[pick]} - 17'd1;
               2: edge_addr = sb.end_addr[pick] - 17'd1;
               3: edge_addr = sb.end_addr[pick];
               default: edge_addr = {1'b0, sb.base_addr[pick]} + 17'($urandom_range(0, 255));
            endcase
            r.address = edge_addr[15:0];
         end
      end
      return r;
   endfunction

   // Receiver: checks at the rising edge, picks the next pop at the falling edge.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_pop    = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            sb.check_response(rsp_data);
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 0;
            stall_left  = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: a hang or a lost result ends the run here.
   initial begin : watchdog
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, sb.pending());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : sender
      sb          = new();
      quiet       = 0;
      hold_wanted = 0;
      clock       = 1'b0;
      reset       = 1'b1;
      req_push    = 1'b0;
      req_data    = '0;

      // synchronous reset, released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == QUIET_FROM)
            quiet = 1;
         if (n == HOLD_AT)
            hold_wanted = 1;  // sender keeps pushing while the receiver sits
         if (n == DRAIN_AT) begin
            req_push <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
            @(negedge clock);
         end
         if (!quiet && $urandom_range(0, 7) == 0)
            idle_sender($urandom_range(1, 14));
         send_request(random_request());
      end
      req_push <= 1'b0;

      // drain, then give the block time to show any stray result
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/brd_pkg.sv
rtl/core/brd_front.sv
rtl/core/brd_queue.sv
rtl/core/brd_back.sv
rtl/core/bus_region_decoder.sv
dv/bus_region_decoder_test.sv
